[rtl/gbr_pkg.sv]
// shared types, constants and the kernel weight table of the 13x13 gaussian blur
// no dependencies; the line store, the filter and the top level import this package
package gbr_pkg;

    localparam int RADIUS        = 6;
    localparam int SPAN          = 2 * RADIUS + 1;
    localparam int WEIGHT_BITS   = 16;
    localparam int CH_BITS       = 8;
    localparam int PIX_BITS      = 3 * CH_BITS;
    localparam int HGT_BITS      = 13;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_BITS      = 13;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;
    localparam int SUM_BITS      = 26;
    localparam int TOT_BITS      = SUM_BITS + 4;
    localparam int CH_MAX        = (1 << CH_BITS) - 1;

    typedef logic [0:0]          t_cfg_idx;
    typedef logic [CFG_BITS-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 1'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 1'd1;

    typedef logic [PIX_BITS-1:0]   t_pixel;
    typedef t_pixel [SPAN-1:0]     t_column;
    typedef t_pixel [SPAN-2:0]     t_line;

    typedef struct packed {
        logic [CH_BITS-1:0] red_in;
        logic [CH_BITS-1:0] green_in;
        logic [CH_BITS-1:0] blue_in;
        logic               flush;
    } t_pix_in;

    typedef struct packed {
        logic [CH_BITS-1:0] red_out;
        logic [CH_BITS-1:0] green_out;
        logic [CH_BITS-1:0] blue_out;
        logic               frame_last;
    } t_pix_out;

    typedef struct packed {
        logic shift;
        logic sum_load;
        logic out_load;
        logic pass;
    } t_filt_ctrl;

    // q0.16 weight for the tap at window column x, row y (squared distance)
    function automatic logic [WEIGHT_BITS-1:0] tap_weight(input int x, input int y);
        int d;
        logic [WEIGHT_BITS-1:0] w;
        d = (x - RADIUS) * (x - RADIUS) + (y - RADIUS) * (y - RADIUS);
        unique case (d)
            0:       w = 16'd10430;
            1:       w = 16'd6326;
            2:       w = 16'd3837;
            3:       w = 16'd2327;
            4:       w = 16'd1412;
            5:       w = 16'd856;
            6:       w = 16'd519;
            7:       w = 16'd315;
            8:       w = 16'd191;
            9:       w = 16'd116;
            10:      w = 16'd70;
            11:      w = 16'd43;
            12:      w = 16'd26;
            13:      w = 16'd16;
            14:      w = 16'd10;
            15:      w = 16'd6;
            16:      w = 16'd3;
            17:      w = 16'd2;
            18:      w = 16'd1;
            19:      w = 16'd1;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

[rtl/gbr_stream_if.sv]
// valid/ready stream channel carrying one payload item per request
// payload type is supplied by the instantiating level (gbr_pkg structs)
interface gbr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/gbr_line_store.sv]
// line store: per image column, the twelve pixels above the current one
// read-modify-write column memory; depends on gbr_pkg
module gbr_line_store #(
    parameter int MAX_WIDTH = gbr_pkg::DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  gbr_pkg::t_pixel              i_pixel,
    output gbr_pkg::t_column             o_column
);
    import gbr_pkg::*;

    t_line r_mem [MAX_WIDTH];
    t_line r_rdata;

    // newest pixel on top, stored column below it
    always_comb begin
        o_column[0] = i_pixel;
        for (int m = 1; m < SPAN; m++) begin
            o_column[m] = r_rdata[m-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= o_column[SPAN-2:0];
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/gbr_filter.sv]
// 13x13 window registers and the weighted sum pipeline (row sums, total, clamp)
// depends on gbr_pkg
module gbr_filter (
    input  logic                i_clk,
    input  gbr_pkg::t_filt_ctrl i_ctrl,
    input  gbr_pkg::t_column    i_column,
    output gbr_pkg::t_pixel     o_pixel
);
    import gbr_pkg::*;

    t_pixel                r_win [SPAN][SPAN];
    logic [SUM_BITS-1:0]   r_row [SPAN][3];
    logic [SUM_BITS-1:0]   n_row [SPAN][3];
    t_pixel                r_center;
    t_pixel                r_out;
    t_pixel                n_blur;

    // per-row weighted sums, one per channel
    always_comb begin
        for (int y = 0; y < SPAN; y++) begin
            for (int c = 0; c < 3; c++) begin
                n_row[y][c] = '0;
                for (int x = 0; x < SPAN; x++) begin
                    n_row[y][c] = n_row[y][c] + SUM_BITS'(tap_weight(x, y))
                                  * SUM_BITS'(r_win[x][y][CH_BITS*c +: CH_BITS]);
                end
            end
        end
    end

    // total, drop fraction, clamp
    always_comb begin
        logic [TOT_BITS-1:0] tot;
        logic [TOT_BITS-1:0] scaled;
        n_blur = '0;
        for (int c = 0; c < 3; c++) begin
            tot = '0;
            for (int y = 0; y < SPAN; y++) begin
                tot = tot + TOT_BITS'(r_row[y][c]);
            end
            scaled = tot >> WEIGHT_BITS;
            if (scaled > TOT_BITS'(CH_MAX)) begin
                n_blur[CH_BITS*c +: CH_BITS] = CH_BITS'(CH_MAX);
            end else begin
                n_blur[CH_BITS*c +: CH_BITS] = scaled[CH_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int y = 0; y < SPAN; y++) begin
                r_win[0][y] <= i_column[y];
            end
            for (int x = 1; x < SPAN; x++) begin
                r_win[x] <= r_win[x-1];
            end
        end
        if (i_ctrl.sum_load) begin
            r_row    <= n_row;
            r_center <= r_win[RADIUS][RADIUS];
        end
        if (i_ctrl.out_load) begin
            r_out <= i_ctrl.pass ? r_center : n_blur;
        end
    end

    assign o_pixel = r_out;

endmodule

[rtl/gaussian_blur_13x13_rgb.sv]
// top level of the 13x13 rgb gaussian blur: stream control, counters, config
// depends on gbr_pkg, gbr_stream_if, gbr_line_store and gbr_filter
//
// Takes one rgb pixel per clock in raster order and returns one blurred pixel
// per clock; a request can be taken every cycle, also while a finished result
// waits on the output register, until the stages ahead of it are full.
// Results trail the input by 6*W+6 requests
// (W = image width), so after a frame's last pixel the source sends that many
// flush requests to drain it; a flush that arrives mid-frame is taken and
// dropped, a pixel that arrives during the drain counts as a flush. Pixels
// within six of any image edge come out unchanged, all others are the 13x13
// q0.16 weighted sum, truncated and clamped to 255. Once a request is taken,
// the line store read happens at the accepting edge, then the window shift,
// the row sums and the total and clamp are registered in turn; each stage
// can stall while the output is not ready.
// The throughput is set by the single line store memory (MAX_WIDTH entries of
// twelve pixels) with one read and one write port, used once per request.
// The store needs no clearing after reset. Image width (index 0) and height
// (index 1) are written on the config port between frames; they are clamped
// to [13, MAX_WIDTH] and [13, 4096] and take effect at the next frame start.
module gaussian_blur_13x13_rgb #(
    parameter int MAX_WIDTH = gbr_pkg::DEF_MAX_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  gbr_pkg::t_cfg_idx   i_cfg_idx,
    input  gbr_pkg::t_cfg_data  i_cfg_data,
    gbr_stream_if.sink          i_pix,
    gbr_stream_if.source        o_pix
);
    import gbr_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = WW + 3;
    localparam int CB = 14;

    // config registers and frame size latched at frame start
    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [HGT_BITS-1:0]   r_cfg_h;
    logic                  r_fresh, n_fresh;
    logic [WW-1:0]         r_w, n_w;
    logic [HGT_BITS-1:0]   r_h, n_h;

    // write position, drain flag, delay count, output position
    logic [AW-1:0]         r_col, n_col;
    logic [HGT_BITS-1:0]   r_row, n_row;
    logic                  r_drain, n_drain;
    logic [DW-1:0]         r_taken, n_taken;
    logic [AW-1:0]         r_ocol, n_ocol;
    logic [HGT_BITS-1:0]   r_orow, n_orow;

    // pipeline stage flags
    logic                  r1_valid, r1_out, r1_edge, r1_last;
    t_pixel                r1_pix;
    logic [AW-1:0]         r1_addr;
    logic                  r2_valid, r2_edge, r2_last;
    logic                  r3_valid, r3_edge, r3_last;
    logic                  r4_valid, r4_last;

    logic                  adv4, free3, free2, free1;
    logic                  accept, eff, has_out, o_last, edge_px;
    logic                  col_end, row_last;
    logic [WW-1:0]         clamp_w, cur_w;
    logic [HGT_BITS-1:0]   clamp_h, cur_h;
    logic [DW-1:0]         delay;
    t_column               column;
    t_pixel                filt_pix;
    t_filt_ctrl            ctrl;

    // stall chain: a stage moves when the one after it is empty or moving
    assign adv4   = !r4_valid || o_pix.ready;
    assign free3  = !r3_valid || adv4;
    assign free2  = !r2_valid || free3;
    assign free1  = !r1_valid || free2;
    assign accept = i_pix.valid && free1;
    // flush requests inside the frame leave no trace
    assign eff    = accept && (r_drain || !i_pix.data.flush);

    // clamp the configured size
    always_comb begin
        logic [CB-1:0] ew;
        logic [CB-1:0] eh;
        ew = CB'(r_cfg_w);
        eh = CB'(r_cfg_h);
        if (ew > CB'(MAX_WIDTH)) begin
            ew = CB'(MAX_WIDTH);
        end else if (ew < CB'(SPAN)) begin
            ew = CB'(SPAN);
        end
        if (eh > CB'(MAX_HEIGHT)) begin
            eh = CB'(MAX_HEIGHT);
        end else if (eh < CB'(SPAN)) begin
            eh = CB'(SPAN);
        end
        clamp_w = ew[WW-1:0];
        clamp_h = eh[HGT_BITS-1:0];
    end

    assign cur_w    = r_fresh ? clamp_w : r_w;
    assign cur_h    = r_fresh ? clamp_h : r_h;
    assign delay    = DW'(RADIUS) * DW'(cur_w) + DW'(RADIUS);
    assign has_out  = (r_taken == delay);
    assign col_end  = (CB'(r_col) + CB'(1)) == CB'(cur_w);
    assign row_last = (CB'(r_row) + CB'(1)) == CB'(cur_h);
    assign o_last   = ((CB'(r_ocol) + CB'(1)) == CB'(cur_w))
                   && ((CB'(r_orow) + CB'(1)) == CB'(cur_h));
    // border pixels pass through
    assign edge_px  = (CB'(r_orow) < CB'(RADIUS)) || (CB'(r_ocol) < CB'(RADIUS))
                   || ((CB'(r_orow) + CB'(RADIUS)) >= CB'(cur_h))
                   || ((CB'(r_ocol) + CB'(RADIUS)) >= CB'(cur_w));

    // frame bookkeeping per request
    always_comb begin
        n_fresh = r_fresh;
        n_w     = r_w;
        n_h     = r_h;
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_taken = r_taken;
        n_ocol  = r_ocol;
        n_orow  = r_orow;
        if (accept && r_fresh) begin
            n_w = clamp_w;
            n_h = clamp_h;
        end
        if (eff) begin
            n_fresh = 1'b0;
            // column keeps running through the drain to address the store
            if (col_end) begin
                n_col = '0;
                if (!r_drain) begin
                    n_row = r_row + HGT_BITS'(1);
                    if (row_last) begin
                        n_drain = 1'b1;
                    end
                end
            end else begin
                n_col = r_col + AW'(1);
            end
            if (has_out) begin
                if (o_last) begin
                    n_fresh = 1'b1;
                    n_col   = '0;
                    n_row   = '0;
                    n_drain = 1'b0;
                    n_taken = '0;
                    n_ocol  = '0;
                    n_orow  = '0;
                end else if ((CB'(r_ocol) + CB'(1)) == CB'(cur_w)) begin
                    n_ocol = '0;
                    n_orow = r_orow + HGT_BITS'(1);
                end else begin
                    n_ocol = r_ocol + AW'(1);
                end
            end else begin
                n_taken = r_taken + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= CFG_W_BITS'(RST_WIDTH);
            r_cfg_h  <= HGT_BITS'(RST_HEIGHT);
            r_fresh  <= 1'b1;
            r_w      <= '0;
            r_h      <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= 1'b0;
            r_taken  <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                    CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[HGT_BITS-1:0];
                    default:          r_cfg_w <= r_cfg_w;
                endcase
            end
            r_fresh <= n_fresh;
            r_w     <= n_w;
            r_h     <= n_h;
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            r_taken <= n_taken;
            r_ocol  <= n_ocol;
            r_orow  <= n_orow;
            if (free1) begin
                r1_valid <= eff;
            end
            if (free2) begin
                r2_valid <= r1_valid && r1_out;
            end
            if (free3) begin
                r3_valid <= r2_valid;
            end
            if (adv4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r1_out  <= has_out;
            r1_edge <= edge_px;
            r1_last <= o_last;
            r1_pix  <= {i_pix.data.red_in, i_pix.data.green_in, i_pix.data.blue_in};
            r1_addr <= r_col;
        end
        if (free2) begin
            r2_edge <= r1_edge;
            r2_last <= r1_last;
        end
        if (free3) begin
            r3_edge <= r2_edge;
            r3_last <= r2_last;
        end
        if (adv4) begin
            r4_last <= r3_last;
        end
    end

    assign ctrl.shift    = r1_valid && free2;
    assign ctrl.sum_load = r2_valid && free3;
    assign ctrl.out_load = r3_valid && adv4;
    assign ctrl.pass     = r3_edge;

    gbr_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (eff),
        .i_rd_addr (r_col),
        .i_wr_en   (ctrl.shift),
        .i_wr_addr (r1_addr),
        .i_pixel   (r1_pix),
        .o_column  (column)
    );

    gbr_filter u_filter (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_column (column),
        .o_pixel  (filt_pix)
    );

    assign i_pix.ready           = free1;
    assign o_pix.valid           = r4_valid;
    assign o_pix.data.red_out    = filt_pix[3*CH_BITS-1:2*CH_BITS];
    assign o_pix.data.green_out  = filt_pix[2*CH_BITS-1:CH_BITS];
    assign o_pix.data.blue_out   = filt_pix[CH_BITS-1:0];
    assign o_pix.data.frame_last = r4_last;

    // the frame's last result returns all bookkeeping to frame start
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff && has_out && o_last) |=> (r_fresh && !r_drain && r_taken == '0))
        else $error("frame end did not reset bookkeeping");

    // the drain begins exactly after the last row was written
    a_drain_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_row == r_h))
        else $error("drain with rows left");

    a_drain_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drain) |-> (r_col == '0))
        else $error("drain did not start at a row boundary");

endmodule
